/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold at a clock edge
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed: never");

// when a holds, b holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: next");

`endif

/* hdl/hpt_pkg.sv */
package hpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int COEF_W     = 32;
    localparam int EPS_W      = 31;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_ROW0_A  = 3'd0;
    localparam t_cfg_idx REG_MIX_B   = 3'd1;
    localparam t_cfg_idx REG_ROW1_C  = 3'd2;
    localparam t_cfg_idx REG_ROW2_D  = 3'd3;
    localparam t_cfg_idx REG_CORNER  = 3'd4;
    localparam t_cfg_idx REG_EPSILON = 3'd5;

    localparam logic [CFG_DATA_W-1:0] RST_ROW0_A = 64'h0001_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_MIX_B  = 64'h0;
    localparam logic [CFG_DATA_W-1:0] RST_ROW1_C = 64'h0001_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW2_D = 64'h0;
    localparam logic [COEF_W-1:0]     RST_CORNER = 32'h0001_0000;
    localparam logic [EPS_W-1:0]      RST_EPS    = 31'h0;

    typedef logic [1:0] t_status;

    localparam t_status ST_AFFINE    = 2'd0;
    localparam t_status ST_DIVIDED   = 2'd1;
    localparam t_status ST_NEAR_ZERO = 2'd2;

    // control group that travels down the divider chain with each word
    typedef struct packed {
        logic    valid;
        logic    div;
        logic    neg_x;
        logic    neg_y;
        t_status status;
        logic    sat;
        logic    last;
    } t_ctl;

endpackage

/* hdl/homography_point_transform.sv */
// throughput: one point per cycle while no stalled result holds the pipeline;
// products, row sums and the divider cells are all pipelined
// the divider is a chain of COORD_WIDTH + FRAC_BITS cells, one quotient bit per cell
// a stalled result freezes the whole pipeline; bubbles fill while the output is empty
// synchronous active-low reset clears valid bits and loads the identity matrix, epsilon 0
`include "assert_macros.svh"

module homography_point_transform #(
    parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hpt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_WIDTH-1:0]       i_point_x,
    input  logic signed [COORD_WIDTH-1:0]       i_point_y,
    input  logic                                i_last_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [COORD_WIDTH-1:0]       o_out_x,
    output logic signed [COORD_WIDTH-1:0]       o_out_y,
    output logic [1:0]                          o_status,
    output logic                                o_saturated,
    output logic                                o_last_out
);
    import hpt_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int N  = W + F;
    localparam int CW = (W + 2 > 32) ? W + 2 : 32;
    localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< F;
    localparam logic [N-1:0] QMAX = {{(F+1){1'b0}}, {(W-1){1'b1}}};

    logic [CFG_DATA_W-1:0] r_row0_a, r_mix_b, r_row1_c, r_row2_d;
    logic [COEF_W-1:0]     r_corner;
    logic [EPS_W-1:0]      r_eps;

    logic w_adv;
    logic r1_valid, r1_last, r2_valid, r2_last;

    logic signed [W-1:0] w_xs, w_ys, w_ws;
    logic                w_sx, w_sy, w_sw;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0_a <= RST_ROW0_A;
            r_mix_b  <= RST_MIX_B;
            r_row1_c <= RST_ROW1_C;
            r_row2_d <= RST_ROW2_D;
            r_corner <= RST_CORNER;
            r_eps    <= RST_EPS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW0_A:  r_row0_a <= i_cfg_data;
                REG_MIX_B:   r_mix_b  <= i_cfg_data;
                REG_ROW1_C:  r_row1_c <= i_cfg_data;
                REG_ROW2_D:  r_row2_d <= i_cfg_data;
                REG_CORNER:  r_corner <= i_cfg_data[COEF_W-1:0];
                REG_EPSILON: r_eps    <= i_cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    hpt_row_unit #(.W(W), .F(F)) u_row_x (
        .i_clk (i_clk), .i_en (w_adv),
        .i_a   (r_row0_a[63:32]), .i_b (r_row0_a[31:0]), .i_c (r_mix_b[63:32]),
        .i_x   (i_point_x), .i_y (i_point_y),
        .o_sum (w_xs), .o_sat (w_sx)
    );

    hpt_row_unit #(.W(W), .F(F)) u_row_y (
        .i_clk (i_clk), .i_en (w_adv),
        .i_a   (r_mix_b[31:0]), .i_b (r_row1_c[63:32]), .i_c (r_row1_c[31:0]),
        .i_x   (i_point_x), .i_y (i_point_y),
        .o_sum (w_ys), .o_sat (w_sy)
    );

    hpt_row_unit #(.W(W), .F(F)) u_row_w (
        .i_clk (i_clk), .i_en (w_adv),
        .i_a   (r_row2_d[63:32]), .i_b (r_row2_d[31:0]), .i_c (r_corner),
        .i_x   (i_point_x), .i_y (i_point_y),
        .o_sum (w_ws), .o_sat (w_sw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_last <= i_last_in;
            r2_last <= r1_last;
        end
    end

    // divide setup: status, signs and magnitudes
    t_ctl            n3_ctl;
    logic [W-1:0]    n3_d, n3_ax, n3_ay;
    logic signed [CW-1:0] w_wc, w_dw, w_adw, w_aw, w_epsc;

    always_comb begin
        w_wc   = CW'(w_ws);
        w_dw   = w_wc - ONE_C;
        w_adw  = w_dw[CW-1] ? -w_dw : w_dw;
        w_aw   = w_wc[CW-1] ? -w_wc : w_wc;
        w_epsc = CW'(r_eps);
        n3_ctl.valid = r2_valid;
        n3_ctl.last  = r2_last;
        n3_ctl.sat   = w_sx | w_sy | w_sw;
        n3_ctl.neg_x = w_xs[W-1] ^ w_ws[W-1];
        n3_ctl.neg_y = w_ys[W-1] ^ w_ws[W-1];
        if (!(w_adw > w_epsc)) begin
            n3_ctl.status = ST_AFFINE;
        end else if (w_aw <= w_epsc) begin
            n3_ctl.status = ST_NEAR_ZERO;
        end else begin
            n3_ctl.status = ST_DIVIDED;
        end
        n3_ctl.div = (n3_ctl.status == ST_DIVIDED);
        n3_d  = n3_ctl.div ? w_aw[W-1:0] : W'(1);
        n3_ax = w_xs[W-1] ? W'(-w_xs) : W'(w_xs);
        n3_ay = w_ys[W-1] ? W'(-w_ys) : W'(w_ys);
    end

    t_ctl                c_ctl [0:N];
    logic [W-1:0]        c_d   [0:N];
    logic [W-1:0]        c_rx  [0:N];
    logic [W-1:0]        c_ry  [0:N];
    logic [N-1:0]        c_qx  [0:N];
    logic [N-1:0]        c_qy  [0:N];
    logic signed [W-1:0] c_px  [0:N];
    logic signed [W-1:0] c_py  [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_ctl[0] <= '0;
        end else if (w_adv) begin
            c_ctl[0] <= n3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            c_d[0]  <= n3_d;
            c_rx[0] <= '0;
            c_ry[0] <= '0;
            c_qx[0] <= {n3_ax, {F{1'b0}}};
            c_qy[0] <= {n3_ay, {F{1'b0}}};
            c_px[0] <= w_xs;
            c_py[0] <= w_ys;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        hpt_div_cell #(.W(W), .N(N)) u_cell (
            .i_clk   (i_clk),      .i_rst_n (i_rst_n),   .i_en   (w_adv),
            .i_ctl   (c_ctl[k]),   .i_d     (c_d[k]),
            .i_rem_x (c_rx[k]),    .i_rem_y (c_ry[k]),
            .i_nq_x  (c_qx[k]),    .i_nq_y  (c_qy[k]),
            .i_px    (c_px[k]),    .i_py    (c_py[k]),
            .o_ctl   (c_ctl[k+1]), .o_d     (c_d[k+1]),
            .o_rem_x (c_rx[k+1]),  .o_rem_y (c_ry[k+1]),
            .o_nq_x  (c_qx[k+1]),  .o_nq_y  (c_qy[k+1]),
            .o_px    (c_px[k+1]),  .o_py    (c_py[k+1])
        );
    end

    // sign, clamp and select the result
    t_ctl                w_fc;
    logic [N-1:0]        w_mx, w_my, w_nx, w_ny;
    logic                w_cx, w_cy;
    logic signed [W-1:0] n_x, n_y;
    logic                n_sat;

    always_comb begin
        w_fc = c_ctl[N];
        w_mx = c_qx[N];
        w_my = c_qy[N];
        w_nx = -w_mx;
        w_ny = -w_my;
        w_cx = w_fc.neg_x ? (w_mx > QMAX + N'(1)) : (w_mx > QMAX);
        w_cy = w_fc.neg_y ? (w_my > QMAX + N'(1)) : (w_my > QMAX);
        n_sat = w_fc.sat;
        if (w_fc.div) begin
            if (w_cx) begin
                n_x = w_fc.neg_x ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                n_x = w_fc.neg_x ? w_nx[W-1:0] : w_mx[W-1:0];
            end
            if (w_cy) begin
                n_y = w_fc.neg_y ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                n_y = w_fc.neg_y ? w_ny[W-1:0] : w_my[W-1:0];
            end
            n_sat = w_fc.sat | w_cx | w_cy;
        end else begin
            n_x = c_px[N];
            n_y = c_py[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= w_fc.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_out_x     <= n_x;
            o_out_y     <= n_y;
            o_status    <= w_fc.status;
            o_saturated <= n_sat;
            o_last_out  <= w_fc.last;
        end
    end

    `ASSERT_NEVER(a_status_code, i_clk, i_rst_n, o_valid && (o_status == 2'd3))
    `ASSERT_NEXT(a_pipe_frozen, i_clk, i_rst_n, !w_adv, $stable(r2_valid) && $stable(c_ctl[0]))
    `ASSERT_NEVER(a_affine_sat, i_clk, i_rst_n, w_fc.valid && !w_fc.div && (n_sat != w_fc.sat))

endmodule

/* hdl/hpt_row_unit.sv */
module hpt_row_unit #(
    parameter int W = hpt_pkg::COORD_WIDTH_DEF,
    parameter int F = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [hpt_pkg::COEF_W-1:0] i_a,
    input  logic signed [hpt_pkg::COEF_W-1:0] i_b,
    input  logic signed [hpt_pkg::COEF_W-1:0] i_c,
    input  logic signed [W-1:0]               i_x,
    input  logic signed [W-1:0]               i_y,
    output logic signed [W-1:0]               o_sum,
    output logic                              o_sat
);
    import hpt_pkg::*;

    localparam int PW = COEF_W + W;
    localparam int SW = PW - F + 2;
    localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

    logic signed [PW-1:0]     r_pa, r_pb;
    logic signed [COEF_W-1:0] r_c;
    logic signed [SW-1:0]     w_fa, w_fb, w_s;
    logic signed [W-1:0]      n_sum;
    logic                     n_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa  <= PW'(i_a) * PW'(i_x);
            r_pb  <= PW'(i_b) * PW'(i_y);
            r_c   <= i_c;
            o_sum <= n_sum;
            o_sat <= n_sat;
        end
    end

    // arithmetic shift gives the floor of each product
    always_comb begin
        w_fa = SW'(r_pa >>> F);
        w_fb = SW'(r_pb >>> F);
        w_s  = w_fa + w_fb + SW'(r_c);
        if (w_s > SMAX) begin
            n_sum = SMAX[W-1:0];
            n_sat = 1'b1;
        end else if (w_s < SMIN) begin
            n_sum = SMIN[W-1:0];
            n_sat = 1'b1;
        end else begin
            n_sum = w_s[W-1:0];
            n_sat = 1'b0;
        end
    end

endmodule

/* hdl/hpt_div_cell.sv */
`include "assert_macros.svh"

module hpt_div_cell #(
    parameter int W = hpt_pkg::COORD_WIDTH_DEF,
    parameter int N = hpt_pkg::COORD_WIDTH_DEF + hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  hpt_pkg::t_ctl        i_ctl,
    input  logic [W-1:0]         i_d,
    input  logic [W-1:0]         i_rem_x,
    input  logic [W-1:0]         i_rem_y,
    input  logic [N-1:0]         i_nq_x,
    input  logic [N-1:0]         i_nq_y,
    input  logic signed [W-1:0]  i_px,
    input  logic signed [W-1:0]  i_py,
    output hpt_pkg::t_ctl        o_ctl,
    output logic [W-1:0]         o_d,
    output logic [W-1:0]         o_rem_x,
    output logic [W-1:0]         o_rem_y,
    output logic [N-1:0]         o_nq_x,
    output logic [N-1:0]         o_nq_y,
    output logic signed [W-1:0]  o_px,
    output logic signed [W-1:0]  o_py
);
    import hpt_pkg::*;

    logic [W:0]   w_rx, w_ry, w_dx, w_dy;
    logic         w_gx, w_gy;
    logic [W-1:0] n_rem_x, n_rem_y;
    logic [N-1:0] n_nq_x, n_nq_y;

    // one restoring step: dividend bits leave the top, quotient bits enter the bottom
    always_comb begin
        w_rx    = {i_rem_x, i_nq_x[N-1]};
        w_ry    = {i_rem_y, i_nq_y[N-1]};
        w_dx    = w_rx - {1'b0, i_d};
        w_dy    = w_ry - {1'b0, i_d};
        w_gx    = w_rx >= {1'b0, i_d};
        w_gy    = w_ry >= {1'b0, i_d};
        n_rem_x = w_gx ? w_dx[W-1:0] : w_rx[W-1:0];
        n_rem_y = w_gy ? w_dy[W-1:0] : w_ry[W-1:0];
        n_nq_x  = {i_nq_x[N-2:0], w_gx};
        n_nq_y  = {i_nq_y[N-2:0], w_gy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d     <= i_d;
            o_rem_x <= n_rem_x;
            o_rem_y <= n_rem_y;
            o_nq_x  <= n_nq_x;
            o_nq_y  <= n_nq_y;
            o_px    <= i_px;
            o_py    <= i_py;
        end
    end

    `ASSERT_NEVER(a_zero_divisor, i_clk, i_rst_n, i_ctl.valid && i_ctl.div && (i_d == '0))

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hpt_pkg::*;

    localparam int       DRAIN_CYCLES = 60;
    localparam int       IDLE_LIMIT   = 5000;
    localparam int       HOLD_CYCLES  = 400;
    localparam int       RAND_PHASES  = 8;
    localparam int       PHASE_POINTS = 150;
    localparam t_cfg_idx REG_UNUSED   = 3'd7;
    localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE   = 32'sh0001_0000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        t_status            status;
        logic               sat;
        logic               last;
    } point_t;

    typedef struct {
        bit                 is_cfg;
        t_cfg_idx           idx;
        logic [63:0]        data;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
        bit                 typed;
        point_t             want;
    } step_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_cfg_idx    i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic        i_last_in = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic [1:0]  o_status;
    logic        o_saturated;
    logic        o_last_out;

    // mirror of the matrix registers
    logic [63:0] row0_q, mix_q, row1_q, row2_q;
    logic [31:0] corner_q;
    logic [30:0] eps_q;

    point_t expected_points[$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     hold_req = 0;
    bit     hold_taken = 0;
    int     hold_cnt = 0;
    int     stall_pct = 0;
    int     pattern_cnt = 0;

    homography_point_transform dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_coord(input longint v, inout bit f);
        if (v > longint'(C_MAX)) begin
            f = 1;
            return longint'(C_MAX);
        end
        if (v < longint'(C_MIN)) begin
            f = 1;
            return longint'(C_MIN);
        end
        return v;
    endfunction

    function automatic point_t transform_point(logic signed [31:0] px, logic signed [31:0] py,
                                               logic last);
        longint m00 = $signed(row0_q[63:32]);
        longint m01 = $signed(row0_q[31:0]);
        longint m02 = $signed(mix_q[63:32]);
        longint m10 = $signed(mix_q[31:0]);
        longint m11 = $signed(row1_q[63:32]);
        longint m12 = $signed(row1_q[31:0]);
        longint m20 = $signed(row2_q[63:32]);
        longint m21 = $signed(row2_q[31:0]);
        longint m22 = $signed(corner_q);
        longint eps = longint'(eps_q);
        longint x = px;
        longint y = py;
        longint xs, ys, ws, dw;
        bit     sat = 0;
        point_t r;
        // products floor to the fraction width, then rows sum exactly
        xs = clamp_coord(((m00 * x) >>> 16) + ((m01 * y) >>> 16) + m02, sat);
        ys = clamp_coord(((m10 * x) >>> 16) + ((m11 * y) >>> 16) + m12, sat);
        ws = clamp_coord(((m20 * x) >>> 16) + ((m21 * y) >>> 16) + m22, sat);
        r.status = ST_AFFINE;
        dw = ws - 65536;
        if (dw < 0) dw = -dw;
        if (dw > eps) begin
            if ((ws < 0 ? -ws : ws) <= eps) begin
                r.status = ST_NEAR_ZERO;
            end else begin
                r.status = ST_DIVIDED;
                xs = clamp_coord((xs * 65536) / ws, sat);
                ys = clamp_coord((ys * 65536) / ws, sat);
            end
        end
        r.x = xs[31:0];
        r.y = ys[31:0];
        r.sat = sat;
        r.last = last;
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ROW0_A:  row0_q = data;
            REG_MIX_B:   mix_q = data;
            REG_ROW1_C:  row1_q = data;
            REG_ROW2_D:  row2_q = data;
            REG_CORNER:  corner_q = data[31:0];
            REG_EPSILON: eps_q = data[30:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // offer one word and hold it until taken
    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py, logic last,
                              bit typed, point_t want);
        i_valid <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        i_last_in <= last;
        do @(posedge i_clk); while (o_stall);
        expected_points.push_back(typed ? want : transform_point(px, py, last));
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return C_MAX;
            1: return C_MIN;
            2: return $urandom();
            3: return 32'(ONE + $signed($urandom_range(0, 4096)) - 2048);
            default: return 32'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return C_MAX;
            1: return C_MIN;
            2, 3: return $urandom();
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    // receiver: own stall pattern plus one long hold-off on request
    always @(posedge i_clk) begin
        pattern_cnt <= pattern_cnt + 1;
        if (pattern_cnt % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 10;
                2: stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
        end
        if (hold_cnt != 0) begin
            i_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1;
            hold_cnt <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        point_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = expected_points.pop_front();
                if (o_out_x !== e.x) begin
                    $error("out_x expected %h got %h", e.x, o_out_x);
                    errors++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y expected %h got %h", e.y, o_out_y);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status expected %0d got %0d", e.status, o_status);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated expected %0d got %0d", e.sat, o_saturated);
                    errors++;
                end
                if (o_last_out !== e.last) begin
                    $error("last_out expected %0d got %0d", e.last, o_last_out);
                    errors++;
                end
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        step_t  plan[$];
        step_t  s;
        point_t none;
        int     sent;
        int     burst;
        none = '{default: '0};
        row0_q = RST_ROW0_A;
        mix_q = RST_MIX_B;
        row1_q = RST_ROW1_C;
        row2_q = RST_ROW2_D;
        corner_q = RST_CORNER;
        eps_q = RST_EPS;

        // identity after reset: words pass straight through
        plan.push_back('{0, '0, '0, 0, 0, 0, 1, '{0, 0, ST_AFFINE, 0, 0}});
        plan.push_back('{0, '0, '0, C_MAX, C_MAX, 1, 1, '{C_MAX, C_MAX, ST_AFFINE, 0, 1}});
        plan.push_back('{0, '0, '0, C_MIN, C_MIN, 0, 1, '{C_MIN, C_MIN, ST_AFFINE, 0, 0}});
        plan.push_back('{0, '0, '0, C_MAX, C_MIN, 1, 1, '{C_MAX, C_MIN, ST_AFFINE, 0, 1}});
        plan.push_back('{0, '0, '0, ONE, -ONE, 0, 1, '{ONE, -ONE, ST_AFFINE, 0, 0}});
        // w = 0 with epsilon 0: undivided, near zero
        plan.push_back('{1, REG_CORNER, 64'h0, 0, 0, 0, 0, none});
        plan.push_back('{0, '0, '0, 2 * ONE, 3 * ONE, 1, 1,
                         '{2 * ONE, 3 * ONE, ST_NEAR_ZERO, 0, 1}});
        // w = 2.0: divided
        plan.push_back('{1, REG_CORNER, 64'h0002_0000, 0, 0, 0, 0, none});
        plan.push_back('{0, '0, '0, 4 * ONE, 2 * ONE, 0, 1, '{2 * ONE, ONE, ST_DIVIDED, 0, 0}});
        plan.push_back('{0, '0, '0, C_MIN, C_MAX, 1, 0, none});
        // tiny w: quotient clamps
        plan.push_back('{1, REG_CORNER, 64'h1, 0, 0, 0, 0, none});
        plan.push_back('{0, '0, '0, C_MAX, C_MIN, 0, 0, none});
        plan.push_back('{0, '0, '0, ONE, ONE, 0, 0, none});
        // sum overflow
        plan.push_back('{1, REG_ROW0_A, {C_MAX, C_MAX}, 0, 0, 0, 0, none});
        plan.push_back('{1, REG_MIX_B, {C_MIN, C_MIN}, 0, 0, 0, 0, none});
        plan.push_back('{1, REG_ROW2_D, {C_MIN, C_MAX}, 0, 0, 0, 0, none});
        plan.push_back('{0, '0, '0, C_MAX, C_MAX, 1, 0, none});
        plan.push_back('{0, '0, '0, C_MIN, C_MIN, 0, 0, none});
        plan.push_back('{1, REG_ROW1_C, {C_MIN, C_MAX}, 0, 0, 0, 0, none});
        plan.push_back('{1, REG_EPSILON, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0, none});
        plan.push_back('{0, '0, '0, C_MAX, C_MIN, 1, 0, none});
        // unknown index is ignored
        plan.push_back('{1, REG_UNUSED, 64'h1234_5678_9abc_def0, 0, 0, 0, 0, none});
        plan.push_back('{0, '0, '0, -ONE, C_MAX, 0, 0, none});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            s = plan[k];
            if (s.is_cfg) begin
                drain();
                write_reg(s.idx, s.data);
            end else begin
                send_point(s.x, s.y, s.last, s.typed, s.want);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            if (ph == 1) begin
                write_reg(REG_ROW0_A, '1);
                write_reg(REG_MIX_B, '1);
                write_reg(REG_ROW1_C, '1);
                write_reg(REG_ROW2_D, '1);
                write_reg(REG_CORNER, '1);
                write_reg(REG_EPSILON, '1);
            end else if (ph == 2) begin
                write_reg(REG_ROW0_A, {C_MIN, C_MIN});
                write_reg(REG_MIX_B, {C_MIN, C_MIN});
                write_reg(REG_ROW1_C, {C_MIN, C_MIN});
                write_reg(REG_ROW2_D, {C_MIN, C_MIN});
                write_reg(REG_CORNER, 64'(C_MIN));
                write_reg(REG_EPSILON, 64'h0);
            end else begin
                write_reg(REG_ROW0_A, {rand_coef(), rand_coef()});
                write_reg(REG_MIX_B, {rand_coef(), rand_coef()});
                write_reg(REG_ROW1_C, {rand_coef(), rand_coef()});
                // small perspective terms keep w near one most of the time
                write_reg(REG_ROW2_D, ($urandom_range(0, 2) == 0) ?
                          {rand_coef(), rand_coef()} :
                          {32'($signed($urandom_range(0, 512)) - 256),
                           32'($signed($urandom_range(0, 512)) - 256)});
                write_reg(REG_CORNER, ($urandom_range(0, 3) == 0) ? 64'(rand_coef()) : 64'(ONE));
                write_reg(REG_EPSILON, 64'($urandom_range(0, 3) == 0 ? $urandom() :
                                           $urandom_range(0, 2048)));
            end
            if (ph == 3) hold_req = 1;
            sent = 0;
            while (sent < PHASE_POINTS) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && sent < PHASE_POINTS; b++) begin
                    send_point(rand_coord(), rand_coord(), $urandom_range(0, 1), 0, none);
                    sent++;
                end
                if (ph != 3 && $urandom_range(0, 2) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* homography_point_transform.f */
+incdir+hdl
hdl/hpt_pkg.sv
hdl/hpt_row_unit.sv
hdl/hpt_div_cell.sv
hdl/homography_point_transform.sv
tb/sv/tb_top.sv
